// File: src/lrsa_pkg.sv
package lrsa_pkg;

    localparam int NUM_REGS      = 256;
    localparam int PROTECT_SLOTS = 8;
    localparam int SCOPE_SLOTS   = 16;

    localparam int OP_W     = 4;
    localparam int REG_W    = 9;
    localparam int CNT_W    = 9;
    localparam int IDX_W    = 3;
    localparam int ST_W     = 2;
    localparam int SCOPE_LW = 5;
    localparam int PROT_LW  = 4;

    localparam int PROT_AW  = (PROTECT_SLOTS > 1) ? $clog2(PROTECT_SLOTS) : 1;
    localparam int SCOPE_AW = (SCOPE_SLOTS > 1) ? $clog2(SCOPE_SLOTS) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_RESET       = 4'd0,
        OP_ALLOC_LOCAL = 4'd1,
        OP_ALLOC_TEMP  = 4'd2,
        OP_FREE        = 4'd3,
        OP_RESERVE     = 4'd4,
        OP_SET_TOP     = 4'd5,
        OP_SET_LOCALS  = 4'd6,
        OP_MARK_LOCAL  = 4'd7,
        OP_PROT_PUSH   = 4'd8,
        OP_PROT_POP    = 4'd9,
        OP_PROT_QUERY  = 4'd10,
        OP_SCOPE_ENTER = 4'd11,
        OP_SCOPE_EXIT  = 4'd12,
        OP_IS_LOCAL    = 4'd13,
        OP_STATUS      = 4'd14
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK           = 2'd0,
        ST_INVALID      = 2'd1,
        ST_FREE_IGNORED = 2'd2,
        ST_POP_MISMATCH = 2'd3
    } t_status;

    typedef struct packed {
        logic capture;
        logic exec;
        logic q_step;
    } t_dp_cmd;

    typedef struct packed {
        logic q_walk;
        logic q_end;
    } t_dp_stat;

endpackage

// File: src/lrsa_ram.sv
module lrsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lrsa_ctrl.sv
module lrsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lrsa_pkg::t_dp_stat i_stat,
    output lrsa_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import lrsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_QUERY
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // a query with regions on the stack walks them one per cycle
                if (i_stat.q_walk) begin
                    n_state = S_QUERY;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_QUERY: begin
                o_cmd.q_step = 1'b1;
                if (i_stat.q_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: src/lrsa_dp.sv
module lrsa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrsa_pkg::t_dp_cmd             i_cmd,
    output lrsa_pkg::t_dp_stat            o_stat,
    input  logic [lrsa_pkg::OP_W-1:0]     i_opcode,
    input  logic [lrsa_pkg::REG_W-1:0]    i_reg_value,
    input  logic [lrsa_pkg::CNT_W-1:0]    i_count_value,
    input  logic [lrsa_pkg::IDX_W-1:0]    i_region_index,
    output logic                          o_valid,
    output logic [lrsa_pkg::ST_W-1:0]     o_status,
    output logic [lrsa_pkg::REG_W-1:0]    o_answer,
    output logic                          o_hit,
    output logic [lrsa_pkg::REG_W-1:0]    o_free_top,
    output logic [lrsa_pkg::REG_W-1:0]    o_locals_end,
    output logic [lrsa_pkg::REG_W-1:0]    o_high_watermark,
    output logic [lrsa_pkg::SCOPE_LW-1:0] o_scope_level,
    output logic [lrsa_pkg::PROT_LW-1:0]  o_protect_level
);
    import lrsa_pkg::*;

    localparam int GW = REG_W + CNT_W;
    localparam logic [REG_W-1:0] NUM_R = REG_W'(NUM_REGS);

    // request captured at accept
    t_op               r_op;
    logic [REG_W-1:0]  r_rv;
    logic [CNT_W-1:0]  r_cv;
    logic [IDX_W-1:0]  r_idx;
    logic [PROT_AW-1:0] r_q_idx;

    // counters
    logic [REG_W-1:0]    r_top, n_top;
    logic [REG_W-1:0]    r_loc, n_loc;
    logic [REG_W-1:0]    r_peak, n_peak;
    logic [PROT_LW-1:0]  r_gd, n_gd;
    logic [SCOPE_LW-1:0] r_nd, n_nd;

    // result
    logic             r_valid;
    t_status          r_status, n_status;
    logic [REG_W-1:0] r_answer, n_answer;
    logic             r_hit, n_hit;

    logic              g_we;
    logic [PROT_AW-1:0] g_raddr;
    logic [GW-1:0]     g_rdata;
    logic [REG_W-1:0]  g_start;
    logic [CNT_W-1:0]  g_len;
    logic [REG_W:0]    g_end;
    logic              q_match;

    logic                s_we;
    logic [SCOPE_LW-1:0] nd_dec;
    logic [REG_W-1:0]    s_rdata;

    logic [REG_W-1:0] top_inc;
    logic [REG_W-1:0] top_dec;
    logic [REG_W:0]   res_sum;
    logic [REG_W-1:0] clamp_rv;
    logic [REG_W-1:0] set_v;
    logic [REG_W-1:0] mark_v;

    lrsa_ram #(
        .WIDTH(GW),
        .DEPTH(PROTECT_SLOTS)
    ) u_guard_ram (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_waddr(r_gd[PROT_AW-1:0]),
        .i_wdata({r_rv, r_cv}),
        .i_raddr(g_raddr),
        .o_rdata(g_rdata)
    );

    lrsa_ram #(
        .WIDTH(REG_W),
        .DEPTH(SCOPE_SLOTS)
    ) u_scope_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(r_nd[SCOPE_AW-1:0]),
        .i_wdata(r_loc),
        .i_raddr(nd_dec[SCOPE_AW-1:0]),
        .o_rdata(s_rdata)
    );

    // entry 0 is read ahead outside the walk, then one entry ahead during the walk
    assign g_raddr = i_cmd.q_step ? (r_q_idx + PROT_AW'(1)) : '0;
    assign g_start = g_rdata[GW-1:CNT_W];
    assign g_len   = g_rdata[CNT_W-1:0];
    assign g_end   = {1'b0, g_start} + {1'b0, g_len};
    assign q_match = (r_rv >= g_start) && ({1'b0, r_rv} < g_end);

    assign o_stat.q_walk = (r_op == OP_PROT_QUERY) && (r_gd != '0);
    assign o_stat.q_end  = q_match || (PROT_LW'(r_q_idx) == (r_gd - PROT_LW'(1)));

    // scope save for the top entry is read continuously
    assign nd_dec = r_nd - SCOPE_LW'(1);

    assign top_inc  = r_top + REG_W'(1);
    assign top_dec  = r_top - REG_W'(1);
    assign res_sum  = {1'b0, r_top} + {1'b0, r_cv};
    assign clamp_rv = (r_rv > NUM_R) ? NUM_R : r_rv;
    assign set_v    = (clamp_rv < r_loc) ? r_loc : clamp_rv;
    assign mark_v   = (r_rv >= r_loc) ? (r_rv + REG_W'(1)) : r_loc;

    always_comb begin
        n_top    = r_top;
        n_loc    = r_loc;
        n_peak   = r_peak;
        n_gd     = r_gd;
        n_nd     = r_nd;
        n_status = ST_OK;
        n_answer = '0;
        n_hit    = 1'b0;
        g_we     = 1'b0;
        s_we     = 1'b0;
        case (r_op)
            OP_RESET: begin
                n_top  = '0;
                n_loc  = '0;
                n_peak = '0;
                n_gd   = '0;
                n_nd   = '0;
            end
            OP_ALLOC_LOCAL, OP_ALLOC_TEMP: begin
                if (r_top >= NUM_R) begin
                    n_status = ST_INVALID;
                end else begin
                    n_answer = r_top;
                    n_top    = top_inc;
                    if (r_op == OP_ALLOC_LOCAL) begin
                        n_loc = top_inc;
                    end
                    if (top_inc > r_peak) begin
                        n_peak = top_inc;
                    end
                end
            end
            OP_FREE: begin
                if (r_rv < r_loc || r_top == '0 || r_rv != top_dec) begin
                    n_status = ST_FREE_IGNORED;
                end else begin
                    n_top = top_dec;
                end
            end
            OP_RESERVE: begin
                if (r_cv == '0 || res_sum > (REG_W+1)'(NUM_REGS)) begin
                    n_status = ST_INVALID;
                end else begin
                    n_answer = r_top;
                    n_top    = res_sum[REG_W-1:0];
                    if (res_sum[REG_W-1:0] > r_peak) begin
                        n_peak = res_sum[REG_W-1:0];
                    end
                end
            end
            OP_SET_TOP: begin
                n_top = set_v;
                if (set_v > r_peak) begin
                    n_peak = set_v;
                end
            end
            OP_SET_LOCALS: begin
                n_loc = clamp_rv;
                if (r_top < clamp_rv) begin
                    n_top = clamp_rv;
                end
            end
            OP_MARK_LOCAL: begin
                if (r_rv >= NUM_R) begin
                    n_status = ST_INVALID;
                end else begin
                    n_loc = mark_v;
                    if (r_top < mark_v) begin
                        n_top = mark_v;
                    end
                    if (mark_v > r_peak) begin
                        n_peak = mark_v;
                    end
                end
            end
            OP_PROT_PUSH: begin
                if (r_gd >= PROT_LW'(PROTECT_SLOTS)) begin
                    n_status = ST_INVALID;
                end else begin
                    g_we     = 1'b1;
                    n_answer = REG_W'(r_gd);
                    n_gd     = r_gd + PROT_LW'(1);
                end
            end
            OP_PROT_POP: begin
                if (r_gd == '0 || PROT_LW'(r_idx) != (r_gd - PROT_LW'(1))) begin
                    n_status = ST_POP_MISMATCH;
                end
                if (r_gd != '0) begin
                    n_gd = r_gd - PROT_LW'(1);
                end
            end
            OP_PROT_QUERY: begin
                // empty protect stack: never a hit
            end
            OP_SCOPE_ENTER: begin
                if (r_nd >= SCOPE_LW'(SCOPE_SLOTS)) begin
                    n_status = ST_INVALID;
                end else begin
                    s_we = 1'b1;
                    n_nd = r_nd + SCOPE_LW'(1);
                end
            end
            OP_SCOPE_EXIT: begin
                if (r_nd == '0) begin
                    n_status = ST_INVALID;
                end else begin
                    n_nd  = nd_dec;
                    n_loc = s_rdata;
                    n_top = s_rdata;
                end
            end
            OP_IS_LOCAL: begin
                n_hit = (r_rv < r_loc);
            end
            OP_STATUS: begin
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_loc   <= '0;
            r_peak  <= '0;
            r_gd    <= '0;
            r_nd    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec || (i_cmd.q_step && o_stat.q_end);
            if (i_cmd.exec) begin
                r_top   <= n_top;
                r_loc   <= n_loc;
                r_peak  <= n_peak;
                r_gd    <= n_gd;
                r_nd    <= n_nd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_opcode);
            r_rv    <= i_reg_value;
            r_cv    <= i_count_value;
            r_idx   <= i_region_index;
            r_q_idx <= '0;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_answer <= n_answer;
            r_hit    <= n_hit;
        end
        if (i_cmd.q_step) begin
            if (o_stat.q_end) begin
                r_status <= ST_OK;
                r_answer <= '0;
                r_hit    <= q_match;
            end else begin
                r_q_idx <= r_q_idx + PROT_AW'(1);
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_answer         = r_answer;
    assign o_hit            = r_hit;
    assign o_free_top       = r_top;
    assign o_locals_end     = r_loc;
    assign o_high_watermark = r_peak;
    assign o_scope_level    = r_nd;
    assign o_protect_level  = r_gd;

endmodule

// File: src/lifo_register_stack_allocator_top.sv
// stack allocator for a register file: hands out registers in strict lifo order,
// tracks a locals boundary, a high watermark, a stack of protected regions and a
// stack of saved locals boundaries for nested scopes.
// request channel: drive the opcode and operand ports and raise start; the request
// is taken at a rising edge where start is high and busy is low.
// result channel: o_valid is high for exactly one cycle with status, answer, hit and
// the counters as they stand after the operation; the receiver cannot stall it, and
// the counter ports keep showing the current values between results.
// o_valid is registered from the execute state for every opcode but a protected-region
// query; a query with regions on the stack walks them from entry 0 upwards and ends at
// the first entry that holds the register, or at the top entry on a miss, since the
// region memory is read one entry per cycle. busy drops in the o_valid cycle, so a new
// request can be accepted there, and no new request is taken before its result is shown.
// reset (i_rst_n low at a clock edge) clears all counters and both stack depths;
// region and scope memories keep their contents and are only used below the depth.
module lifo_register_stack_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lrsa_pkg::OP_W-1:0]     i_opcode,
    input  logic [lrsa_pkg::REG_W-1:0]    i_reg_value,
    input  logic [lrsa_pkg::CNT_W-1:0]    i_count_value,
    input  logic [lrsa_pkg::IDX_W-1:0]    i_region_index,
    output logic                          o_valid,
    output logic [lrsa_pkg::ST_W-1:0]     o_status,
    output logic [lrsa_pkg::REG_W-1:0]    o_answer,
    output logic                          o_hit,
    output logic [lrsa_pkg::REG_W-1:0]    o_free_top,
    output logic [lrsa_pkg::REG_W-1:0]    o_locals_end,
    output logic [lrsa_pkg::REG_W-1:0]    o_high_watermark,
    output logic [lrsa_pkg::SCOPE_LW-1:0] o_scope_level,
    output logic [lrsa_pkg::PROT_LW-1:0]  o_protect_level
);
    import lrsa_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lrsa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (dp_stat),
        .o_cmd  (dp_cmd),
        .o_busy (busy)
    );

    lrsa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_opcode        (i_opcode),
        .i_reg_value     (i_reg_value),
        .i_count_value   (i_count_value),
        .i_region_index  (i_region_index),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_answer        (o_answer),
        .o_hit           (o_hit),
        .o_free_top      (o_free_top),
        .o_locals_end    (o_locals_end),
        .o_high_watermark(o_high_watermark),
        .o_scope_level   (o_scope_level),
        .o_protect_level (o_protect_level)
    );

endmodule

// File: src/lrsa_chk.sv
module lrsa_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [lrsa_pkg::ST_W-1:0]  o_status,
    input logic [lrsa_pkg::REG_W-1:0] o_answer,
    input logic [lrsa_pkg::REG_W-1:0] o_free_top,
    input logic [lrsa_pkg::REG_W-1:0] o_locals_end
);
    import lrsa_pkg::*;

    // a result frees the block in the same cycle
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // one result per request, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back to back results");

    a_answer_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_answer == '0))
        else $error("answer nonzero on failed request");

    // free top never sits below the locals boundary
    a_top_above_locals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_free_top >= o_locals_end))
        else $error("free top below locals boundary");

endmodule

bind lifo_register_stack_allocator_top lrsa_chk u_lrsa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_answer    (o_answer),
    .o_free_top  (o_free_top),
    .o_locals_end(o_locals_end)
);
